// ===== design/klt_pkg.sv =====
// ----------------------------------------------------------------------------
// klt_pkg
// Shared constants and types for the keyed lag table: table geometry,
// field widths, register map and the configuration bus bundle.
// ----------------------------------------------------------------------------
package klt_pkg;

    localparam int NUM_LANES  = 4;
    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    // fixed field geometry of the stream words
    localparam int FIELD_W    = 64;
    localparam int LANE_SLOTS = 4;
    localparam int S_DATA_W   = (2 + LANE_SLOTS) * FIELD_W;
    localparam int M_DATA_W   = LANE_SLOTS * FIELD_W;
    localparam int M_USER_W   = 2;

    // configuration port
    localparam int CFG_REGS  = 4;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = $clog2(CFG_REGS * 8);
    localparam int CFG_IDX_W = $clog2(CFG_REGS);

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_C = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_D = CFG_IDX_W'(3);

    // table geometry
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit SET_POW2  = ((SETS & (SETS - 1)) == 0);
    localparam int KEY_ROW_W = WAYS * KEY_BITS;
    localparam int VAL_ROW_W = WAYS * NUM_LANES * VALUE_BITS;

    // set index reduction for a non power of two set count: 8 key bits a cycle
    localparam int RED_STEPS = 8;
    localparam int RED_CYC   = (KEY_BITS + RED_STEPS - 1) / RED_STEPS;
    localparam int RED_W     = RED_CYC * RED_STEPS;
    localparam int RED_CNT_W = $clog2(RED_CYC + 1);

    typedef struct packed {
        logic              sel;
        logic              enable;
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } apb_req_t;

    typedef logic [LANE_SLOTS-1:0][FIELD_W-1:0] dflt_t;

endpackage

// ===== design/klt_ram.sv =====
// ----------------------------------------------------------------------------
// klt_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module klt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/klt_cfg.sv =====
// ----------------------------------------------------------------------------
// klt_cfg
// Register file for the per-lane default lag values, written and read over
// the configuration bus.
// ----------------------------------------------------------------------------
module klt_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  klt_pkg::apb_req_t         apb,
    output logic [klt_pkg::DATA_W-1:0] prdata,
    output klt_pkg::dflt_t            dflt
);

    import klt_pkg::*;

    dflt_t                dflt_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx = apb.addr[ADDR_W-1 -: CFG_IDX_W];
    assign wr  = apb.sel & apb.enable & apb.write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_DEFAULT_A: dflt_reg[0] <= apb.wdata;
                REG_DEFAULT_B: dflt_reg[1] <= apb.wdata;
                REG_DEFAULT_C: dflt_reg[2] <= apb.wdata;
                REG_DEFAULT_D: dflt_reg[3] <= apb.wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEFAULT_A: prdata = dflt_reg[0];
            REG_DEFAULT_B: prdata = dflt_reg[1];
            REG_DEFAULT_C: prdata = dflt_reg[2];
            REG_DEFAULT_D: prdata = dflt_reg[3];
            default:       prdata = '0;
        endcase
    end

    assign dflt = dflt_reg;

endmodule

// ===== design/keyed_lag_table.sv =====
// ----------------------------------------------------------------------------
// keyed_lag_table
// Per-partition lag over a row stream, set-associative table kept in RAM.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*; each holds group key, partition key and four
// lane values. Each word gives exactly one result word on m_t*: the values
// last stored under the same partition key within the current group, or the
// configured defaults, plus found/dropped flags in m_tuser.
// A new group key (or the first word after reset) invalidates the table.
// Sequence: the accept edge reads the set row from the key and value RAMs;
// in the lookup state, once the output register is free, the block compares
// the ways, loads the output register and writes the updated row back. A
// word is taken only after the previous word's RAM row is written back. With
// a non power of two set count, the set index is first reduced 8 key bits
// per cycle and the row is read at the last reduction step, not at accept.
// The output register holds the result while m_tready is low; the next
// input word is still taken and waits in the compare stage until the
// output register frees up.
// Reset clears the defaults, the valid bits and the group tracking; RAM
// contents need no clearing since only valid ways are looked at.
// ----------------------------------------------------------------------------
module keyed_lag_table (
    input  logic                          clk,
    input  logic                          rst_n,
    // group_key, partition_key, value_a, value_b, value_c, value_d
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [klt_pkg::S_DATA_W-1:0]  s_tdata,
    // lag_a, lag_b, lag_c, lag_d
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [klt_pkg::M_DATA_W-1:0]  m_tdata,
    // found, dropped
    output logic [klt_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [klt_pkg::ADDR_W-1:0]    paddr,
    input  logic [klt_pkg::DATA_W-1:0]    pwdata,
    output logic [klt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import klt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    apb_req_t apb;
    dflt_t    dflt;

    logic                                   s_hs;
    logic [FIELD_W-1:0]                     in_group;
    logic [FIELD_W-1:0]                     in_part;
    logic [LANE_SLOTS-1:0][FIELD_W-1:0]     in_val;
    logic [SET_W-1:0]                       in_set;
    logic                                   grp_clr;

    logic [FIELD_W-1:0]                     last_group_reg;
    logic                                   group_seen_reg;
    logic [SETS-1:0][WAYS-1:0]              valid_reg;

    logic [KEY_BITS-1:0]                    key_reg;
    logic [NUM_LANES-1:0][VALUE_BITS-1:0]   val_reg;
    logic [SET_W-1:0]                       set_reg;
    logic [RED_W-1:0]                       red_reg;
    logic [RED_CNT_W-1:0]                   red_cnt_reg;
    logic                                   red_last;
    logic [SET_W:0]                         red_t;
    logic [SET_W-1:0]                       red_rem;

    logic                                   rd_en;
    logic [SET_W-1:0]                       rd_addr;
    logic [KEY_ROW_W-1:0]                   key_row, key_wrow;
    logic [VAL_ROW_W-1:0]                   val_row, val_wrow;
    logic                                   key_we, val_we;

    logic [WAYS-1:0]                        vrow;
    logic [WAYS-1:0]                        hit_vec, free_vec, hit_oh, free_oh, slot_oh;
    logic                                   hit_done, free_done;
    logic                                   hit, have_free, insert;
    logic [VALUE_BITS-1:0]                  lane_val;
    logic [LANE_SLOTS-1:0][FIELD_W-1:0]     lag_next;

    logic                                   out_free, lk_fire;
    logic                                   out_valid_reg;
    logic [LANE_SLOTS-1:0][FIELD_W-1:0]     lag_reg;
    logic                                   found_reg, dropped_reg;

    // ---- configuration ----
    assign apb.sel    = psel;
    assign apb.enable = penable;
    assign apb.write  = pwrite;
    assign apb.addr   = paddr;
    assign apb.wdata  = pwdata;
    assign pready     = 1'b1;

    klt_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .apb    (apb),
        .prdata (prdata),
        .dflt   (dflt)
    );

    // ---- input word ----
    assign in_group = s_tdata[0 +: FIELD_W];
    assign in_part  = s_tdata[FIELD_W +: FIELD_W];
    assign in_val   = s_tdata[2*FIELD_W +: LANE_SLOTS*FIELD_W];
    assign in_set   = SET_W'(in_part & FIELD_W'(SETS - 1));
    assign grp_clr  = !group_seen_reg || (in_group != last_group_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_hs     = s_tvalid & s_tready;

    // ---- set index reduction (non power of two set count only) ----
    assign red_last = (red_cnt_reg == RED_CNT_W'(RED_CYC - 1));

    always_comb
    begin
        red_rem = set_reg;
        red_t   = '0;
        for (int i = 0; i < RED_STEPS; i++)
        begin
            red_t = {red_rem, red_reg[RED_W-1-i]};
            if (red_t >= (SET_W+1)'(SETS))
            begin
                red_t = red_t - (SET_W+1)'(SETS);
            end
            red_rem = red_t[SET_W-1:0];
        end
    end

    // ---- RAM access ----
    always_comb
    begin
        if (SET_POW2)
        begin
            rd_en   = s_hs;
            rd_addr = in_set;
        end
        else
        begin
            rd_en   = (state_reg == ST_REDUCE) && red_last;
            rd_addr = red_rem;
        end
    end

    klt_ram #(
        .WIDTH  (KEY_ROW_W),
        .DEPTH  (SETS),
        .ADDR_W (SET_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (set_reg),
        .wdata (key_wrow),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (key_row)
    );

    klt_ram #(
        .WIDTH  (VAL_ROW_W),
        .DEPTH  (SETS),
        .ADDR_W (SET_W)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (set_reg),
        .wdata (val_wrow),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (val_row)
    );

    // ---- way compare and row update ----
    assign vrow = valid_reg[set_reg];

    always_comb
    begin
        hit_oh    = '0;
        free_oh   = '0;
        hit_done  = 1'b0;
        free_done = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = vrow[w] && (key_row[w*KEY_BITS +: KEY_BITS] == key_reg);
            free_vec[w] = !vrow[w];
            if (hit_vec[w] && !hit_done)
            begin
                hit_oh[w] = 1'b1;
                hit_done  = 1'b1;
            end
            if (free_vec[w] && !free_done)
            begin
                free_oh[w] = 1'b1;
                free_done  = 1'b1;
            end
        end
    end

    assign hit       = |hit_vec;
    assign have_free = |free_vec;
    assign insert    = !hit && have_free;
    assign slot_oh   = hit ? hit_oh : free_oh;

    assign out_free = !out_valid_reg || m_tready;
    assign lk_fire  = (state_reg == ST_LOOKUP) && out_free;
    assign key_we   = lk_fire && insert;
    assign val_we   = lk_fire && (hit || have_free);

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            key_wrow[w*KEY_BITS +: KEY_BITS] =
                free_oh[w] ? key_reg : key_row[w*KEY_BITS +: KEY_BITS];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                val_wrow[(w*NUM_LANES+l)*VALUE_BITS +: VALUE_BITS] =
                    slot_oh[w] ? val_reg[l]
                               : val_row[(w*NUM_LANES+l)*VALUE_BITS +: VALUE_BITS];
            end
        end
    end

    always_comb
    begin
        lag_next = '0;
        lane_val = '0;
        for (int l = 0; l < LANE_SLOTS; l++)
        begin
            if (l < NUM_LANES)
            begin
                lane_val = '0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_oh[w])
                    begin
                        lane_val = lane_val
                                 | val_row[(w*NUM_LANES+l)*VALUE_BITS +: VALUE_BITS];
                    end
                end
                lag_next[l] = hit ? FIELD_W'(lane_val)
                                  : FIELD_W'(dflt[l][VALUE_BITS-1:0]);
            end
        end
    end

    // ---- control ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_hs)
                begin
                    state_next = SET_POW2 ? ST_LOOKUP : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (red_last)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_group_reg <= '0;
            group_seen_reg <= 1'b0;
            valid_reg      <= '0;
            red_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_hs)
            begin
                last_group_reg <= in_group;
                group_seen_reg <= 1'b1;
                red_cnt_reg    <= '0;
            end
            else if (state_reg == ST_REDUCE)
            begin
                red_cnt_reg <= red_cnt_reg + 1'b1;
            end
            if (s_hs && grp_clr)
            begin
                valid_reg <= '0;
            end
            else if (key_we)
            begin
                valid_reg[set_reg] <= vrow | free_oh;
            end
            if (lk_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            key_reg <= in_part[KEY_BITS-1:0];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                val_reg[l] <= in_val[l][VALUE_BITS-1:0];
            end
            set_reg <= SET_POW2 ? in_set : '0;
            red_reg <= RED_W'(in_part[KEY_BITS-1:0]);
        end
        else if (state_reg == ST_REDUCE)
        begin
            set_reg <= red_rem;
            red_reg <= red_reg << RED_STEPS;
        end
        if (lk_fire)
        begin
            lag_reg     <= lag_next;
            found_reg   <= hit;
            dropped_reg <= !hit && !have_free;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lag_reg;
    assign m_tuser  = {dropped_reg, found_reg};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_hs |=> !s_tready)
        else $error("input taken while previous word still in flight");

    a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_hs && grp_clr) |=> (valid_reg == '0))
        else $error("table not invalidated on group change");

    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> $onehot0(hit_vec))
        else $error("partition key stored in more than one way");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and dropped both set");
`endif

endmodule

// ===== verif/keyed_lag_table_test.sv =====
// ----------------------------------------------------------------------------
// keyed_lag_table_test
// Self-checking bench for the keyed lag table. A short directed list covers
// reset state, hits, set overflow, group changes and key extremes. Random
// rows from small key pools follow, so sets fill, hit, update and drop.
// Four settings of the default registers are used. Both stream sides idle at
// random. Each result word is checked against its typed-in lags or an in-bench table model.
// ----------------------------------------------------------------------------
module keyed_lag_table_test;

    import klt_pkg::*;

    typedef struct packed {
        logic [3:0][63:0] value;
        logic [63:0]      partition_key;
        logic [63:0]      group_key;
    } row_t;

    typedef struct packed {
        logic [3:0][63:0] lag;
        logic             found;
        logic             dropped;
    } lag_result_t;

    typedef enum int {PAT_ZERO, PAT_ONES, PAT_ALT, PAT_WALK, PAT_MIX} pat_t;

    // directed row: expected lags are a lane pattern when typed in
    typedef struct {
        logic [63:0] group_key;
        logic [63:0] partition_key;
        pat_t        values;
        bit          typed;
        pat_t        lags;
        bit          found;
        bit          dropped;
    } dir_row_t;

    localparam logic [63:0] ALL_ONES   = '1;
    localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LOW63      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SET0_TOP   = 64'hFFFF_FFFF_FFFF_FFC0;
    localparam logic [63:0] KEY_MASK   = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 1);
    localparam logic [63:0] VALUE_MASK = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 1);
    localparam int          N_DIR      = 20;
    localparam int          HOLD_CYCLES = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // table model state
    logic [63:0]           lag_default [4];
    logic [63:0]           key_mem [SETS*WAYS];
    logic [63:0]           lane_mem [SETS*WAYS][NUM_LANES];
    bit                    entry_valid [SETS*WAYS];
    logic [63:0]           last_group;
    bit                    group_seen;

    lag_result_t           pending_lags [$];
    logic [63:0]           key_pool [$];
    logic [63:0]           group_pool [3];
    logic [63:0]           cur_group;
    dir_row_t              dir_rows [N_DIR];
    int                    mismatches = 0;
    bit                    steady = 1'b0;
    bit                    hold_off_req = 1'b0;

    keyed_lag_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    function automatic logic [3:0][63:0] lane_pattern(input pat_t p);
        logic [3:0][63:0] v;
        case (p)
            PAT_ONES:
            begin
                v = '1;
            end
            PAT_ALT:
            begin
                v[0] = 64'h5555_5555_5555_5555;
                v[1] = 64'hAAAA_AAAA_AAAA_AAAA;
                v[2] = 64'h0123_4567_89AB_CDEF;
                v[3] = 64'hFEDC_BA98_7654_3210;
            end
            PAT_WALK:
            begin
                v[0] = 64'h8000_0000_0000_0001;
                v[1] = 64'h0000_0001_0000_0000;
                v[2] = 64'h0000_0000_FFFF_FFFF;
                v[3] = 64'hFFFF_FFFF_0000_0000;
            end
            PAT_MIX:
            begin
                v[0] = 64'h0F1E_2D3C_4B5A_6978;
                v[1] = 64'h8796_A5B4_C3D2_E1F0;
                v[2] = 64'h1357_9BDF_0246_8ACE;
                v[3] = 64'hDEAD_BEEF_CAFE_F00D;
            end
            default:
            begin
                v = '0;
            end
        endcase
        return v;
    endfunction

    // Looks up one row, returns its lag word and updates the table.
    function automatic lag_result_t lag_lookup(input row_t r);
        logic [63:0] key;
        int          base;
        int          slot;
        int          free_slot;
        bit          hit;
        bit          have_free;
        lag_result_t res;
        key       = r.partition_key & KEY_MASK;
        base      = int'(key % SETS) * WAYS;
        slot      = 0;
        free_slot = 0;
        hit       = 1'b0;
        have_free = 1'b0;
        if (!group_seen || r.group_key != last_group)
        begin
            foreach (entry_valid[e])
            begin
                entry_valid[e] = 1'b0;
            end
            last_group = r.group_key;
            group_seen = 1'b1;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (entry_valid[base + w])
            begin
                if (!hit && key_mem[base + w] == key)
                begin
                    hit  = 1'b1;
                    slot = base + w;
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_slot = base + w;
            end
        end
        res.lag = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            res.lag[l] = hit ? lane_mem[slot][l] : (lag_default[l] & VALUE_MASK);
        end
        res.found   = hit;
        res.dropped = !hit && !have_free;
        if (!hit && have_free)
        begin
            slot              = free_slot;
            entry_valid[slot] = 1'b1;
            key_mem[slot]     = key;
            hit               = 1'b1;
        end
        if (hit)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                lane_mem[slot][l] = r.value[l] & VALUE_MASK;
            end
        end
        return res;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_row(input row_t r, input bit typed, input lag_result_t want);
        int          gap;
        lag_result_t model;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {r.value, r.partition_key, r.group_key};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        model = lag_lookup(r);
        pending_lags = {pending_lags, (typed ? want : model)};
        @(negedge clk);
    endtask

    task automatic make_row(output row_t r);
        int          pick;
        logic [63:0] key;
        if ($urandom_range(59) == 0)
        begin
            cur_group = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                 : group_pool[$urandom_range(2)];
        end
        pick = $urandom_range(99);
        if (pick < 45 && key_pool.size() > 0)
        begin
            key = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        else if (pick < 90)
        begin
            // crowd a few sets so they fill and overflow
            key      = {$urandom, $urandom};
            key[5:0] = 6'($urandom_range(5));
            key_pool = {key_pool, key};
            if (key_pool.size() > 24)
            begin
                void'(key_pool.pop_front());
            end
        end
        else
        begin
            key = {$urandom, $urandom};
        end
        r.group_key     = cur_group;
        r.partition_key = key;
        for (int l = 0; l < 4; l++)
        begin
            r.value[l] = {$urandom, $urandom};
        end
    endtask

    task automatic run_rows(input int count);
        row_t r;
        for (int i = 0; i < count; i++)
        begin
            make_row(r);
            send_row(r, 1'b0, '0);
        end
    endtask

    // Stop offering, let every expected word arrive, then settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_lags.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge after the access, with the bus idle.
    task automatic write_default(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        lag_default[idx] = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_defaults(input logic [63:0] a, input logic [63:0] b,
                                input logic [63:0] c, input logic [63:0] d);
        write_default(REG_DEFAULT_A, a);
        write_default(REG_DEFAULT_B, b);
        write_default(REG_DEFAULT_C, c);
        write_default(REG_DEFAULT_D, d);
    endtask

    // result checker
    always @(posedge clk)
    begin
        lag_result_t got;
        lag_result_t want;
        if (m_tvalid && m_tready)
        begin
            got.lag     = m_tdata;
            got.found   = m_tuser[0];
            got.dropped = m_tuser[1];
            if (pending_lags.size() == 0)
            begin
                flag_mismatch("word with nothing pending, lag_a", got.lag[0], '0);
            end
            else
            begin
                want = pending_lags.pop_front();
                for (int l = 0; l < 4; l++)
                begin
                    if (got.lag[l] !== want.lag[l])
                    begin
                        flag_mismatch($sformatf("lag lane %0d", l), got.lag[l], want.lag[l]);
                    end
                end
                if (got.found !== want.found)
                begin
                    flag_mismatch("found", 64'(got.found), 64'(want.found));
                end
                if (got.dropped !== want.dropped)
                begin
                    flag_mismatch("dropped", 64'(got.dropped), 64'(want.dropped));
                end
            end
        end
    end

    // receiver: random stalls, long hold-off on request, none when steady
    initial
    begin
        int r;
        int n;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (steady)
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                r = $urandom_range(99);
                n = (r < 55) ? $urandom_range(12, 1) :
                    (r < 90) ? $urandom_range(3, 1) : $urandom_range(25, 6);
                m_tready <= (r < 55);
                repeat (n) @(negedge clk);
            end
        end
    end

    // a run that has not finished by this time fails
    initial
    begin
        #4800000;
        $display("keyed_lag_table test failed");
        $finish;
    end

    initial
    begin
        row_t r;
        lag_result_t want;
        foreach (lag_default[i])
        begin
            lag_default[i] = '0;
        end
        foreach (entry_valid[e])
        begin
            entry_valid[e] = 1'b0;
        end
        last_group = '0;
        group_seen = 1'b0;

        // defaults are zero from reset, so PAT_ZERO is the miss value here
        dir_rows = '{
            // first row after reset, group equals the reset group value
            '{64'h0,     64'h0,     PAT_ZERO, 1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{64'h0,     64'h0,     PAT_ONES, 1'b1, PAT_ZERO, 1'b1, 1'b0},
            '{64'h0,     64'h0,     PAT_ALT,  1'b1, PAT_ONES, 1'b1, 1'b0},
            '{64'h0,     64'd64,    PAT_WALK, 1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{64'h0,     64'd128,   PAT_MIX,  1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{64'h0,     SET0_TOP,  PAT_ONES, 1'b1, PAT_ZERO, 1'b0, 1'b0},
            // set 0 full: defaults returned, nothing stored
            '{64'h0,     64'd192,   PAT_ALT,  1'b1, PAT_ZERO, 1'b0, 1'b1},
            '{64'h0,     64'd192,   PAT_WALK, 1'b1, PAT_ZERO, 1'b0, 1'b1},
            '{64'h0,     64'd64,    PAT_ALT,  1'b1, PAT_WALK, 1'b1, 1'b0},
            '{64'h0,     SET0_TOP,  PAT_ONES, 1'b1, PAT_ONES, 1'b1, 1'b0},
            // new group clears the table
            '{ALL_ONES,  64'h0,     PAT_MIX,  1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{ALL_ONES,  ALL_ONES,  PAT_ALT,  1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{ALL_ONES,  ALL_ONES,  PAT_ZERO, 1'b1, PAT_ALT,  1'b1, 1'b0},
            // same set, keys differ only in the top bit
            '{ALL_ONES,  LOW63,     PAT_WALK, 1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{ALL_ONES,  ALL_ONES,  PAT_ONES, 1'b1, PAT_ZERO, 1'b1, 1'b0},
            '{ALL_ONES,  LOW63,     PAT_MIX,  1'b1, PAT_WALK, 1'b1, 1'b0},
            '{TOP_BIT,   64'h0,     PAT_ALT,  1'b1, PAT_ZERO, 1'b0, 1'b0},
            '{TOP_BIT,   TOP_BIT,   PAT_MIX,  1'b0, PAT_ZERO, 1'b0, 1'b0},
            '{TOP_BIT,   64'h0,     PAT_WALK, 1'b0, PAT_ZERO, 1'b0, 1'b0},
            '{TOP_BIT,   64'hC0,    PAT_ONES, 1'b0, PAT_ZERO, 1'b0, 1'b0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r.group_key     = dir_rows[i].group_key;
            r.partition_key = dir_rows[i].partition_key;
            r.value         = lane_pattern(dir_rows[i].values);
            want.lag        = lane_pattern(dir_rows[i].lags);
            want.found      = dir_rows[i].found;
            want.dropped    = dir_rows[i].dropped;
            send_row(r, dir_rows[i].typed, want);
        end
        drain();

        foreach (group_pool[i])
        begin
            group_pool[i] = {$urandom, $urandom};
        end
        cur_group = group_pool[0];

        set_defaults(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        run_rows(50);
        // receiver stops long enough for the block to back up
        hold_off_req = 1'b1;
        run_rows(250);
        drain();

        set_defaults({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        steady = 1'b1;
        run_rows(300);
        drain();
        steady = 1'b0;

        set_defaults('0, '0, '0, '0);
        run_rows(100);
        drain();
        run_rows(200);
        drain();

        set_defaults(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        run_rows(300);
        drain();

        repeat (8) @(posedge clk);
        if (pending_lags.size() != 0)
        begin
            flag_mismatch("result words never arrived", '0, 64'(pending_lags.size()));
        end
        if (mismatches == 0)
        begin
            $display("keyed_lag_table test passed");
        end
        else
        begin
            $display("keyed_lag_table test failed");
        end
        $finish;
    end

endmodule
